// ===== rtl/sdar_pkg.sv =====
`timescale 1ns / 1ps
// Package for the star depth advance and respawn unit.
// Holds controller states, command/status structs, constants and the noise step.
package sdar_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned DRAW_X_W = 9;
    localparam int unsigned DRAW_Y_W = 8;
    localparam int unsigned SPAN_W   = WORD_W + 1;
    localparam int unsigned MOD_STEPS = DRAW_X_W;
    localparam int unsigned CNT_W    = $clog2(MOD_STEPS);
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] NOISE_SEED  = 16'hACE1;
    localparam logic [WORD_W-1:0] SPEED_RST   = 16'd1;
    localparam logic [WORD_W-1:0] FAR_RST     = 16'd127;
    localparam logic [WORD_W-1:0] SPREAD_RST  = 16'd0;
    localparam logic [WORD_W-1:0] CENTRE_X_RST = 16'd160;
    localparam logic [WORD_W-1:0] CENTRE_Y_RST = 16'd112;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MODX,
        ST_MODY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;      // capture input transaction
        logic draw;      // respawn: draw noise twice, set far depth
        logic mod_step;  // one restoring modulo step
        logic mod_last;  // final step of current axis
        logic axis_y;    // 0: x axis, 1: y axis
        logic out_load;  // move result into output register
    } t_cmd;

    typedef struct packed {
        logic respawn;
        logic out_free;
    } t_status;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = s ^ (s << 7);
        b = a ^ (a >> 9);
        return b ^ (b << 8);
    endfunction

endpackage

// ===== rtl/sdar_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the star depth advance and respawn unit.
// Depends on sdar_pkg; drives the datapath through t_cmd.
module sdar_ctrl
    import sdar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_cnt = '0;
                if (i_status.respawn) begin
                    o_cmd.draw = 1'b1;
                    n_state    = ST_MODX;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MODX, ST_MODY: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.axis_y   = (r_state == ST_MODY);
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                    o_cmd.mod_last = 1'b1;
                    n_cnt          = '0;
                    n_state        = (r_state == ST_MODX) ? ST_MODY : ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/sdar_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, noise generator, serial modulo unit
// and output register. Depends on sdar_pkg; steered by sdar_ctrl.
module sdar_dp
    import sdar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic [WORD_W-1:0]    i_star_x,
    input  logic [WORD_W-1:0]    i_star_y,
    input  logic [WORD_W-1:0]    i_star_z,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [WORD_W-1:0]    o_new_x,
    output logic [WORD_W-1:0]    o_new_y,
    output logic [WORD_W-1:0]    o_new_z,
    output logic                 o_respawned
);

    logic [WORD_W-1:0] r_speed, r_far, r_spread_x, r_spread_y, r_centre_x, r_centre_y;
    logic [WORD_W-1:0] r_noise;
    logic [WORD_W-1:0] r_x, r_y, r_z;
    logic              r_resp;
    logic [DRAW_Y_W-1:0] r_dy;
    logic [DRAW_X_W-1:0] r_div;
    logic [SPAN_W-1:0]   r_rem;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_x, r_out_y, r_out_z;
    logic              r_out_resp;

    logic [WORD_W-1:0] n_z;
    logic [WORD_W-1:0] n_d1, n_d2;
    logic [WORD_W-1:0] n_spread, n_centre;
    logic [SPAN_W-1:0] n_span;
    logic [SPAN_W:0]   n_trial;
    logic [SPAN_W-1:0] n_rem;
    logic [WORD_W-1:0] n_place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= SPEED_RST;
            r_far      <= FAR_RST;
            r_spread_x <= SPREAD_RST;
            r_spread_y <= SPREAD_RST;
            r_centre_x <= CENTRE_X_RST;
            r_centre_y <= CENTRE_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SPEED:    r_speed    <= i_cfg_data;
                REG_FAR:      r_far      <= i_cfg_data;
                REG_SPREAD_X: r_spread_x <= i_cfg_data;
                REG_SPREAD_Y: r_spread_y <= i_cfg_data;
                REG_CENTRE_X: r_centre_x <= i_cfg_data;
                REG_CENTRE_Y: r_centre_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_z  = i_star_z - r_speed;
    assign n_d1 = xorshift(r_noise);
    assign n_d2 = xorshift(n_d1);

    // restoring modulo by 2*spread, one dividend bit per step
    assign n_spread = i_cmd.axis_y ? r_spread_y : r_spread_x;
    assign n_centre = i_cmd.axis_y ? r_centre_y : r_centre_x;
    assign n_span   = {n_spread, 1'b0};
    assign n_trial  = {r_rem, r_div[DRAW_X_W-1]};
    assign n_rem    = (n_trial >= {1'b0, n_span}) ? SPAN_W'(n_trial - {1'b0, n_span})
                                                  : n_trial[SPAN_W-1:0];
    assign n_place  = (n_spread[WORD_W-1] || n_spread == '0) ? n_centre
                    : n_centre - n_spread + n_rem[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= NOISE_SEED;
        end else if (i_cmd.draw) begin
            r_noise <= n_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_star_x;
            r_y    <= i_star_y;
            r_z    <= n_z;
            r_resp <= (n_z == '0) || n_z[WORD_W-1];
        end
        if (i_cmd.draw) begin
            r_z   <= r_far;
            r_div <= n_d1[DRAW_X_W-1:0];
            r_dy  <= n_d2[DRAW_Y_W-1:0];
            r_rem <= '0;
        end
        if (i_cmd.mod_step) begin
            if (i_cmd.mod_last) begin
                r_rem <= '0;
                r_div <= {{(DRAW_X_W - DRAW_Y_W){1'b0}}, r_dy};
                if (i_cmd.axis_y) begin
                    r_y <= n_place;
                end else begin
                    r_x <= n_place;
                end
            end else begin
                r_rem <= n_rem;
                r_div <= {r_div[DRAW_X_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_z    <= r_z;
            r_out_resp <= r_resp;
        end
    end

    assign o_status.respawn  = r_resp;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_new_x     = r_out_x;
    assign o_new_y     = r_out_y;
    assign o_new_z     = r_out_z;
    assign o_respawned = r_out_resp;

endmodule

// ===== rtl/star_depth_advance_respawn_unit.sv =====
`timescale 1ns / 1ps
// Star depth advance and respawn: one star in, one updated star out per transaction.
// A star that keeps flying goes from evaluation straight to the output register; one that
// respawns first takes two 9-step serial modulo passes through one shared restoring unit.
// The next star is taken only after the last has moved into the output register, which
// lets it enter while a result waits; a full output register stalls the unit.
// Synchronous active-low reset restores register defaults and the noise seed 0xACE1.
module star_depth_advance_respawn_unit
    import sdar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // star_x, star_y, star_z
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // new_x, new_y, new_z
    output logic                 m_axis_tuser    // respawned
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    sdar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sdar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_star_x    (s_axis_tdata[15:0]),
        .i_star_y    (s_axis_tdata[31:16]),
        .i_star_z    (s_axis_tdata[47:32]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_new_x     (m_axis_tdata[15:0]),
        .o_new_y     (m_axis_tdata[31:16]),
        .o_new_z     (m_axis_tdata[47:32]),
        .o_respawned (m_axis_tuser)
    );

endmodule
